// File: hw/rtl/ipmc_pkg.sv
package ipmc_pkg;

    localparam int TimeoutW = 16;
    localparam int CfgIndexW = 2;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DIM    = 2'd1,
        MODE_BLANK  = 2'd2,
        MODE_SLEEP  = 2'd3
    } mode_t;

    // Item kind carried on the input tuser.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CFG_BLANK_TIMEOUT = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_SLEEP_TIMEOUT = 2'd1;

    typedef enum logic [1:0] {
        TMR_HOLD = 2'd0,
        TMR_STOP = 2'd1,
        TMR_ARM  = 2'd2,
        TMR_TICK = 2'd3
    } tmr_cmd_t;

    typedef struct packed {
        logic active;
        logic expire;
    } tmr_stat_t;

endpackage

// File: hw/rtl/idle_power_mode_controller.sv
// Path: an accepted transaction goes to the input register, then to the result
// register that drives m_tvalid; a result not yet taken by m_tready holds it back.
// Throughput: one transaction per cycle; the input register and the result
// register are both refilled in the same cycle, limited only by m_tready.
// Reset (aresetn low, synchronous): mode normal, both countdowns stopped and
// cleared, both timeouts zero, input and result registers empty.
module idle_power_mode_controller (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // is_idle, idle_inhibited,
                                                          // suspend_inhibited, zero pad
    input  logic                                s_tuser,  // kind

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // mode[1:0], mode_changed,
                                                          // zero pad

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipmc_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [ipmc_pkg::TimeoutW-1:0]       cfg_data
);

    // Configuration registers. Writes are always accepted; an index beyond
    // the two registers is dropped.
    logic [ipmc_pkg::TimeoutW-1:0] blank_timeout_reg;
    logic [ipmc_pkg::TimeoutW-1:0] sleep_timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_timeout_reg <= '0;
            sleep_timeout_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ipmc_pkg::CFG_BLANK_TIMEOUT: blank_timeout_reg <= cfg_data;
                ipmc_pkg::CFG_SLEEP_TIMEOUT: sleep_timeout_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register. It holds one accepted transaction until the result
    // register can take its outcome; state is updated at that same edge, so
    // items are applied strictly in arrival order.
    logic       in_valid_reg;
    logic       kind_reg;
    logic       idle_reg;
    logic       idle_inh_reg;
    logic       susp_inh_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg     <= s_tuser;
            idle_reg     <= s_tdata[0];
            idle_inh_reg <= s_tdata[1];
            susp_inh_reg <= s_tdata[2];
        end
    end

    // Countdown commands. A status update that is not idle, or is inhibited,
    // stops both countdowns; an idle one arms blank and either arms or stops
    // sleep depending on the suspend inhibit. A tick advances both.
    ipmc_pkg::tmr_cmd_t  blank_cmd;
    ipmc_pkg::tmr_cmd_t  sleep_cmd;
    ipmc_pkg::tmr_stat_t blank_stat;
    ipmc_pkg::tmr_stat_t sleep_stat;

    always_comb begin
        blank_cmd = ipmc_pkg::TMR_HOLD;
        sleep_cmd = ipmc_pkg::TMR_HOLD;
        if (advance) begin
            if (kind_reg == ipmc_pkg::KIND_TICK) begin
                blank_cmd = ipmc_pkg::TMR_TICK;
                sleep_cmd = ipmc_pkg::TMR_TICK;
            end else if (!idle_reg || idle_inh_reg) begin
                blank_cmd = ipmc_pkg::TMR_STOP;
                sleep_cmd = ipmc_pkg::TMR_STOP;
            end else begin
                blank_cmd = ipmc_pkg::TMR_ARM;
                sleep_cmd = susp_inh_reg ? ipmc_pkg::TMR_STOP : ipmc_pkg::TMR_ARM;
            end
        end
    end

    ipmc_timer u_blank_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (blank_cmd),
        .timeout (blank_timeout_reg),
        .stat    (blank_stat)
    );

    ipmc_timer u_sleep_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sleep_cmd),
        .timeout (sleep_timeout_reg),
        .stat    (sleep_stat)
    );

    ipmc_pkg::mode_t mode_cur;
    ipmc_pkg::mode_t mode_next;
    logic            mode_changed;

    ipmc_mode u_mode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .kind           (kind_reg),
        .is_idle        (idle_reg),
        .idle_inhibited (idle_inh_reg),
        .blank_stat     (blank_stat),
        .sleep_stat     (sleep_stat),
        .mode           (mode_cur),
        .mode_next      (mode_next),
        .mode_changed   (mode_changed)
    );

    // Result register. It is loaded whenever a transaction leaves the input
    // register, and emptied when the downstream side takes it.
    logic            out_valid_reg;
    ipmc_pkg::mode_t out_mode_reg;
    logic            out_changed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mode_reg    <= mode_next;
            out_changed_reg <= mode_changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_changed_reg, out_mode_reg};

    // A transaction that leaves the input register always shows up as a result.
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result register not loaded after advance");

    // Leaving idle returns to normal and stops both countdowns.
    a_wake_resets_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && kind_reg == ipmc_pkg::KIND_STATUS && (!idle_reg || idle_inh_reg))
        |=> (mode_cur == ipmc_pkg::MODE_NORMAL && !blank_stat.active
             && !sleep_stat.active))
        else $error("wake-up did not clear mode and countdowns");

    // A sleep expiry always lands in sleep mode.
    a_sleep_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        sleep_stat.expire |=> mode_cur == ipmc_pkg::MODE_SLEEP)
        else $error("sleep expiry did not enter sleep mode");

    // The stored mode only moves when a transaction is processed.
    a_mode_stable_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(mode_cur))
        else $error("mode changed without a transaction");

endmodule

// File: hw/rtl/ipmc_timer.sv
module ipmc_timer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ipmc_pkg::tmr_cmd_t                cmd,
    input  logic [ipmc_pkg::TimeoutW-1:0]     timeout,
    output ipmc_pkg::tmr_stat_t               stat
);

    logic [ipmc_pkg::TimeoutW-1:0] remaining_reg;
    logic [ipmc_pkg::TimeoutW-1:0] remaining_next;
    logic                          active_reg;
    logic                          active_next;
    logic [ipmc_pkg::TimeoutW-1:0] rem_dec;
    logic                          expire;

    // A running count found at zero does not wrap; it expires on the next tick.
    assign rem_dec = (remaining_reg != '0) ? remaining_reg - 1'b1 : '0;

    always_comb begin
        remaining_next = remaining_reg;
        active_next    = active_reg;
        expire         = 1'b0;
        unique case (cmd)
            ipmc_pkg::TMR_STOP: begin
                remaining_next = '0;
                active_next    = 1'b0;
            end
            ipmc_pkg::TMR_ARM: begin
                if (!active_reg && (timeout != '0)) begin
                    remaining_next = timeout;
                    active_next    = 1'b1;
                end
            end
            ipmc_pkg::TMR_TICK: begin
                if (active_reg) begin
                    remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        active_next = 1'b0;
                        expire      = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign stat = '{active: active_reg, expire: expire};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            active_reg    <= 1'b0;
        end else begin
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
        end
    end

endmodule

// File: hw/rtl/ipmc_mode.sv
module ipmc_mode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                kind,
    input  logic                is_idle,
    input  logic                idle_inhibited,
    input  ipmc_pkg::tmr_stat_t blank_stat,
    input  ipmc_pkg::tmr_stat_t sleep_stat,
    output ipmc_pkg::mode_t     mode,
    output ipmc_pkg::mode_t     mode_next,
    output logic                mode_changed
);

    ipmc_pkg::mode_t mode_reg;
    ipmc_pkg::mode_t step_mode;

    always_comb begin
        step_mode = mode_reg;
        if (kind == ipmc_pkg::KIND_STATUS) begin
            if (!is_idle || idle_inhibited) begin
                step_mode = ipmc_pkg::MODE_NORMAL;
            end else if (mode_reg == ipmc_pkg::MODE_NORMAL) begin
                step_mode = ipmc_pkg::MODE_DIM;
            end
        end else begin
            // Blank is checked before sleep, so sleep wins when both expire together.
            if (blank_stat.expire && (mode_reg == ipmc_pkg::MODE_NORMAL ||
                                      mode_reg == ipmc_pkg::MODE_DIM)) begin
                step_mode = ipmc_pkg::MODE_BLANK;
            end
            if (sleep_stat.expire) begin
                step_mode = ipmc_pkg::MODE_SLEEP;
            end
        end
    end

    assign mode_next    = advance ? step_mode : mode_reg;
    assign mode_changed = (step_mode != mode_reg);
    assign mode         = mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ipmc_pkg::MODE_NORMAL;
        end else begin
            mode_reg <= mode_next;
        end
    end

endmodule
